### rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, the sequencer state type and the compare unit flags.
// ----------------------------------------------------------------------------
package lkv_pkg;

   // Default number of entries in the store.
   localparam int ENTRIES_DEFAULT = 16;

   // Field widths fixed by the interface.
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request modes.
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Flags produced by the shared compare unit for one stored entry.
   typedef struct packed {
      logic key_eq;     // stored key equals the request key
      logic rank_last;  // entry holds the least recent rank
      logic rank_below; // entry is more recent than the reference rank
   } cmp_flags_type;

endpackage

### rtl/lkv_cmp_unit.sv
// ----------------------------------------------------------------------------
// LRU key-value cache compare unit
// Shared key and rank comparator used on every entry during scan and sweep.
// ----------------------------------------------------------------------------
module lkv_cmp_unit #(
   parameter int RANK_W = 4
) (
   input  logic [lkv_pkg::KEY_W-1:0] stored_key,
   input  logic [lkv_pkg::KEY_W-1:0] req_key,
   input  logic [RANK_W-1:0]         rank,
   input  logic [RANK_W-1:0]         last_rank,
   input  logic [RANK_W-1:0]         ref_rank,
   output lkv_pkg::cmp_flags_type    flags,
   output logic [RANK_W-1:0]         rank_next
);

   // Keys compare as plain bit patterns.
   assign flags.key_eq     = (stored_key == req_key);
   assign flags.rank_last  = (rank == last_rank);
   assign flags.rank_below = (rank < ref_rank);

   // Entries more recent than the reference age by one.
   assign rank_next = flags.rank_below ? (rank + RANK_W'(1)) : rank;

endmodule

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The key scan and the rank sweep each read one entry per cycle. A request
// runs the scan, the decide step, the sweep and the finish step, where the
// result strobe is registered; a get that misses skips the sweep. One
// request at a time: busy stays high until the strobe cycle. Synchronous
// reset empties the store and sets capacity to 16 without clearing the entry
// memories; results cannot stall.
module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic signed [lkv_pkg::KEY_W-1:0] req_key,
   input  logic signed [lkv_pkg::VAL_W-1:0] req_value,
   // Result channel
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic signed [lkv_pkg::VAL_W-1:0] rsp_read_value,
   output logic                             rsp_evicted,
   // Capacity register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]        csr_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // Entry memories.
   logic [lkv_pkg::KEY_W-1:0] key_mem  [ENTRIES];
   logic [lkv_pkg::VAL_W-1:0] val_mem  [ENTRIES];
   logic [IW-1:0]             rank_mem [ENTRIES];

   // Registered read data.
   logic [lkv_pkg::KEY_W-1:0] key_rd_ff;
   logic [lkv_pkg::VAL_W-1:0] val_rd_ff;
   logic [IW-1:0]             rank_rd_ff;

   // Sequencer and request state.
   lkv_pkg::state_type        state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic [IW-1:0]             pidx_ff, pidx_in;
   logic                      mode_ff, mode_in;
   logic [lkv_pkg::KEY_W-1:0] key_ff, key_in;
   logic [lkv_pkg::VAL_W-1:0] value_ff, value_in;
   logic                      found_ff, found_in;
   logic [IW-1:0]             slot_ff, slot_in;
   logic [IW-1:0]             rref_ff, rref_in;
   logic [IW-1:0]             victim_ff, victim_in;
   logic [lkv_pkg::VAL_W-1:0] hitval_ff, hitval_in;
   logic                      upd_ff, upd_in;
   logic                      wkv_ff, wkv_in;
   logic                      insert_ff, insert_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [lkv_pkg::CAP_W-1:0] cap_ff, cap_in;

   // Result registers.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [lkv_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_evicted_ff, rsp_evicted_in;

   // Memory port controls.
   logic [IW-1:0]             rd_addr;
   logic                      rank_we;
   logic [IW-1:0]             rank_waddr;
   logic [IW-1:0]             rank_wdata;
   logic                      kv_we;

   // Derived values.
   logic [IW-1:0]             last_rank;
   logic [CW-1:0]             eff_cap;
   logic                      issue;
   lkv_pkg::cmp_flags_type    flags;
   logic [IW-1:0]             rank_next;

   assign last_rank = IW'(fill_ff - CW'(1));
   assign issue     = (cnt_ff < fill_ff);

   // Capacity clamped to the range one to ENTRIES.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (32'(cap_ff) > ENTRIES) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   // Shared comparator on the entry read back from memory.
   lkv_cmp_unit #(
      .RANK_W (IW)
   ) u_cmp (
      .stored_key (key_rd_ff),
      .req_key    (key_ff),
      .rank       (rank_rd_ff),
      .last_rank  (last_rank),
      .ref_rank   (rref_ff),
      .flags      (flags),
      .rank_next  (rank_next)
   );

   // Entry memories: one read and one write address per cycle.
   always_ff @(posedge clock) begin
      key_rd_ff  <= key_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
      rank_rd_ff <= rank_mem[rd_addr];
      if (kv_we) begin
         key_mem[slot_ff] <= key_ff;
         val_mem[slot_ff] <= value_ff;
      end
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lkv_pkg::ST_IDLE;
         pend_ff        <= 1'b0;
         fill_ff        <= '0;
         cap_ff         <= lkv_pkg::CAP_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         fill_ff        <= fill_in;
         cap_ff         <= cap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cnt_ff         <= cnt_in;
      pidx_ff        <= pidx_in;
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      found_ff       <= found_in;
      slot_ff        <= slot_in;
      rref_ff        <= rref_in;
      victim_ff      <= victim_in;
      hitval_ff      <= hitval_in;
      upd_ff         <= upd_in;
      wkv_ff         <= wkv_in;
      insert_ff      <= insert_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   // Sequencer: next state and memory controls.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pend_in        = 1'b0;
      pidx_in        = cnt_ff[IW-1:0];
      mode_in        = mode_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      rref_in        = rref_ff;
      victim_in      = victim_ff;
      hitval_in      = hitval_ff;
      upd_in         = upd_ff;
      wkv_in         = wkv_ff;
      insert_in      = insert_ff;
      fill_in        = fill_ff;
      cap_in         = cap_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rd_addr        = cnt_ff[IW-1:0];
      rank_we        = 1'b0;
      rank_waddr     = pidx_ff;
      rank_wdata     = rank_next;
      kv_we          = 1'b0;

      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            // Capacity writes are taken only while idle.
            if (csr_valid) begin
               cap_in = csr_data;
            end
            if (start) begin
               mode_in  = req_mode;
               key_in   = req_key;
               value_in = req_value;
               found_in = 1'b0;
               cnt_in   = '0;
               state_in = lkv_pkg::ST_SCAN;
            end
         end

         lkv_pkg::ST_SCAN: begin
            // Issue one read per cycle and check the entry read last cycle.
            pend_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (pend_ff) begin
               if (flags.key_eq && !found_ff) begin
                  found_in  = 1'b1;
                  slot_in   = pidx_ff;
                  rref_in   = rank_rd_ff;
                  hitval_in = val_rd_ff;
               end
               if (flags.rank_last) begin
                  victim_in = pidx_ff;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = lkv_pkg::ST_DECIDE;
            end
         end

         lkv_pkg::ST_DECIDE: begin
            // Pick the entry to touch and the rank that splits the aging.
            rsp_hit_in     = found_ff;
            rsp_value_in   = '0;
            rsp_evicted_in = 1'b0;
            insert_in      = 1'b0;
            upd_in         = 1'b1;
            wkv_in         = 1'b1;
            if (found_ff) begin
               wkv_in = (mode_ff == lkv_pkg::MODE_PUT);
               if (mode_ff == lkv_pkg::MODE_GET) begin
                  rsp_value_in = hitval_ff;
               end
            end else if (mode_ff == lkv_pkg::MODE_PUT) begin
               if (fill_ff >= eff_cap) begin
                  slot_in        = victim_ff;
                  rref_in        = last_rank;
                  rsp_evicted_in = 1'b1;
               end else begin
                  slot_in   = fill_ff[IW-1:0];
                  rref_in   = fill_ff[IW-1:0];
                  insert_in = 1'b1;
               end
            end else begin
               upd_in = 1'b0;
               wkv_in = 1'b0;
            end
            cnt_in   = '0;
            state_in = (found_ff || mode_ff == lkv_pkg::MODE_PUT) ?
                       lkv_pkg::ST_SWEEP : lkv_pkg::ST_FINISH;
         end

         lkv_pkg::ST_SWEEP: begin
            // Age every entry more recent than the reference rank.
            pend_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            rank_we = pend_ff;
            if (!issue && !pend_ff) begin
               state_in = lkv_pkg::ST_FINISH;
            end
         end

         lkv_pkg::ST_FINISH: begin
            // Make the touched entry most recent and post the result.
            rank_we    = upd_ff;
            rank_waddr = slot_ff;
            rank_wdata = '0;
            kv_we      = wkv_ff;
            if (insert_ff) begin
               fill_in = fill_ff + CW'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = lkv_pkg::ST_IDLE;
         end

         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != lkv_pkg::ST_IDLE);
   assign csr_ready      = (state_ff == lkv_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   // The result strobe lasts a single cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // The fill count never passes the number of entries.
   assert property (@(posedge clock) disable iff (reset) 32'(fill_ff) <= ENTRIES)
      else $error("fill count exceeds the number of entries");

   // A result never reports both a hit and an eviction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("result shows hit and eviction together");

   // An accepted request starts the key scan in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == lkv_pkg::ST_SCAN))
      else $error("accepted request did not start the scan");

   // Sweep writes only land on filled entries.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkv_pkg::ST_SWEEP && rank_we) |-> (CW'(rank_waddr) < fill_ff))
      else $error("rank sweep wrote outside the filled entries");

endmodule
